/* hdl/pfo_pkg.sv */
// Shared types, constants and saturation helpers for the flux observer and PLL.
package pfo_pkg;

    localparam int POLE_PAIRS    = 4;
    localparam int PI_Q          = 205887;
    localparam int TWO_PI_Q      = 2 * PI_Q;
    localparam int SPEED_LIMIT   = 68629139 * POLE_PAIRS;
    localparam logic signed [63:0] RPM_K      = 64'sd41013916522;
    localparam logic signed [63:0] RPM_FACTOR = RPM_K / POLE_PAIRS;
    localparam int CORDIC_STEPS  = 17;
    localparam int WRAP_STEPS    = 11;
    localparam int K_ONE         = 65536;

    localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
    localparam logic signed [65:0] S32_MIN = -66'sd2147483648;
    localparam logic signed [65:0] S64_MAX = 66'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [65:0] S64_MIN = -66'sh0_8000_0000_0000_0000;
    localparam logic signed [65:0] SPD_MAX = 66'(SPEED_LIMIT);
    localparam logic signed [65:0] SPD_MIN = -66'(SPEED_LIMIT);

    typedef enum logic [2:0] {
        REG_RS   = 3'd0,
        REG_LS   = 3'd1,
        REG_PSI  = 3'd2,
        REG_GAM  = 3'd3,
        REG_TS   = 3'd4,
        REG_KP   = 3'd5,
        REG_KI   = 3'd6,
        REG_KF   = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SH_0  = 2'd0,
        SH_16 = 2'd1,
        SH_32 = 2'd2,
        SH_33 = 2'd3
    } sh_t;

    // Datapath operation sequence, one shared multiply each.
    typedef enum logic [4:0] {
        OP_RS_IA   = 5'd0,
        OP_RS_IB   = 5'd1,
        OP_LS_IA   = 5'd2,
        OP_LS_IB   = 5'd3,
        OP_EA_SQ   = 5'd4,
        OP_EB_SQ   = 5'd5,
        OP_PSI_SQ  = 5'd6,
        OP_EA_GAM  = 5'd7,
        OP_TA_S    = 5'd8,
        OP_EB_GAM  = 5'd9,
        OP_TB_S    = 5'd10,
        OP_TS_DA   = 5'd11,
        OP_TS_DB   = 5'd12,
        OP_KI_E    = 5'd13,
        OP_KP_E    = 5'd14,
        OP_TS_SPD  = 5'd15,
        OP_SPD_RPM = 5'd16,
        OP_ACC_K   = 5'd17,
        OP_RPM_K   = 5'd18
    } op_t;

    typedef struct packed {
        logic       load_in;
        logic       mul_start;
        op_t        op;
        logic       cordic_start;
        logic       wrap_step;
        logic [3:0] wrap_shift;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic cordic_done;
    } status_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > S32_MAX) return 32'sh7FFF_FFFF;
        else if (v < S32_MIN) return 32'sh8000_0000;
        else return v[31:0];
    endfunction

    function automatic logic signed [63:0] sat64(input logic signed [65:0] v);
        if (v > S64_MAX) return 64'sh7FFF_FFFF_FFFF_FFFF;
        else if (v < S64_MIN) return 64'sh8000_0000_0000_0000;
        else return v[63:0];
    endfunction

    function automatic logic signed [31:0] clamp_speed(input logic signed [65:0] v);
        if (v > SPD_MAX) return SPD_MAX[31:0];
        else if (v < SPD_MIN) return SPD_MIN[31:0];
        else return v[31:0];
    endfunction

    function automatic logic [15:0] atan_entry(input logic [4:0] i);
        logic [15:0] r;
        case (i)
            5'd0:    r = 16'd51472;
            5'd1:    r = 16'd30386;
            5'd2:    r = 16'd16055;
            5'd3:    r = 16'd8150;
            5'd4:    r = 16'd4091;
            5'd5:    r = 16'd2047;
            5'd6:    r = 16'd1024;
            5'd7:    r = 16'd512;
            5'd8:    r = 16'd256;
            5'd9:    r = 16'd128;
            5'd10:   r = 16'd64;
            5'd11:   r = 16'd32;
            5'd12:   r = 16'd16;
            5'd13:   r = 16'd8;
            5'd14:   r = 16'd4;
            5'd15:   r = 16'd2;
            5'd16:   r = 16'd1;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage

/* hdl/pfo_mul.sv */
// Sequential signed 64x64 multiplier with floor shift and 64-bit saturation.
module pfo_mul
    import pfo_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    input  sh_t                sh,
    output logic               done,
    output logic signed [63:0] p
);

    logic         busy_reg;
    logic [2:0]   step_reg;
    logic         done_reg;
    logic [63:0]  ma_reg;
    logic [63:0]  mb_reg;
    logic         neg_reg;
    sh_t          sh_reg;
    logic [127:0] acc_reg;
    logic [63:0]  qlo_reg;
    logic         big_reg;
    logic         rem_reg;
    logic signed [63:0] p_reg;

    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [63:0]  pp;
    logic [127:0] pp_shift;
    logic [127:0] q;
    logic         rem;
    logic [64:0]  lo65;
    logic         ovf;
    logic signed [63:0] p_next;

    always_comb
    begin
        a_half = step_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
        b_half = step_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
        pp     = a_half * b_half;
        case (2'(step_reg[1]) + 2'(step_reg[0]))
            2'd0:    pp_shift = {64'd0, pp};
            2'd1:    pp_shift = {32'd0, pp, 32'd0};
            default: pp_shift = {pp, 64'd0};
        endcase
    end

    always_comb
    begin
        case (sh_reg)
            SH_0:
            begin
                q   = acc_reg;
                rem = 1'b0;
            end
            SH_16:
            begin
                q   = acc_reg >> 16;
                rem = |acc_reg[15:0];
            end
            SH_32:
            begin
                q   = acc_reg >> 32;
                rem = |acc_reg[31:0];
            end
            default:
            begin
                q   = acc_reg >> 33;
                rem = |acc_reg[32:0];
            end
        endcase
    end

    // Negative results round toward minus infinity, so the magnitude rounds up.
    always_comb
    begin
        lo65 = {1'b0, qlo_reg} + 65'(neg_reg & rem_reg);
        ovf  = big_reg | lo65[64] | lo65[63];
        if (ovf)
            p_next = neg_reg ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        else if (neg_reg)
            p_next = -signed'(lo65[63:0]);
        else
            p_next = signed'(lo65[63:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == 3'd5);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 3'd0;
            end
            else if (busy_reg)
            begin
                if (step_reg == 3'd5)
                    busy_reg <= 1'b0;
                step_reg <= step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg  <= a[63] ? 64'(-a) : 64'(a);
            mb_reg  <= b[63] ? 64'(-b) : 64'(b);
            neg_reg <= a[63] ^ b[63];
            sh_reg  <= sh;
            acc_reg <= 128'd0;
        end
        else if (busy_reg)
        begin
            case (step_reg)
                3'd0, 3'd1, 3'd2, 3'd3:
                    acc_reg <= acc_reg + pp_shift;
                3'd4:
                begin
                    qlo_reg <= q[63:0];
                    big_reg <= |q[127:64];
                    rem_reg <= rem;
                end
                default:
                    p_reg <= p_next;
            endcase
        end
    end

    assign done = done_reg;
    assign p    = p_reg;

endmodule

/* hdl/pfo_cordic.sv */
// Vectoring CORDIC atan2, one iteration per clock.
module pfo_cordic
    import pfo_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] x_in,
    input  logic signed [31:0] y_in,
    output logic               done,
    output logic signed [18:0] angle
);

    logic               busy_reg;
    logic               done_reg;
    logic [4:0]         i_reg;
    logic signed [34:0] x_reg;
    logic signed [34:0] y_reg;
    logic signed [20:0] z_reg;
    logic               zero_reg;

    logic signed [34:0] x0;
    logic signed [34:0] y0;
    logic signed [34:0] dx;
    logic signed [34:0] dy;
    logic signed [20:0] at;

    always_comb
    begin
        x0 = 35'(x_in);
        y0 = 35'(y_in);
        dx = y_reg >>> i_reg;
        dy = x_reg >>> i_reg;
        at = 21'(atan_entry(i_reg));
        if (zero_reg)
            angle = 19'sd0;
        else if (z_reg > 21'(PI_Q))
            angle = 19'(PI_Q);
        else if (z_reg < -21'(PI_Q))
            angle = -19'(PI_Q);
        else
            angle = z_reg[18:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= 5'd0;
        end
        else
        begin
            done_reg <= busy_reg && (i_reg == 5'(CORDIC_STEPS - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                i_reg    <= 5'd0;
            end
            else if (busy_reg)
            begin
                if (i_reg == 5'(CORDIC_STEPS - 1))
                    busy_reg <= 1'b0;
                i_reg <= i_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            zero_reg <= (x_in == 32'sd0) && (y_in == 32'sd0);
            // Left half plane: turn the vector by pi first.
            if (x_in < 32'sd0)
            begin
                x_reg <= -x0;
                y_reg <= -y0;
                z_reg <= (y_in >= 32'sd0) ? 21'(PI_Q) : -21'(PI_Q);
            end
            else
            begin
                x_reg <= x0;
                y_reg <= y0;
                z_reg <= 21'sd0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg > 35'sd0)
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
            else
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end
        end
    end

    assign done = done_reg;

endmodule

/* hdl/pfo_datapath.sv */
// Observer and PLL datapath: registers, shared multiplier, CORDIC and angle wrap.
module pfo_datapath
    import pfo_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic signed [31:0] current_alpha,
    input  logic signed [31:0] current_beta,
    input  logic signed [31:0] voltage_alpha,
    input  logic signed [31:0] voltage_beta,
    input  cmd_t               cmd,
    output status_t            status,
    output logic signed [18:0] rotor_angle,
    output logic signed [18:0] flux_angle,
    output logic signed [31:0] elec_speed,
    output logic signed [31:0] speed_rpm_filtered
);

    // Configuration
    logic [22:0] rs_reg;
    logic [31:0] ls_reg;
    logic [31:0] psi_reg;
    logic [31:0] gam_reg;
    logic [31:0] ts_reg;
    logic [31:0] kp_reg;
    logic [31:0] ki_reg;
    logic [16:0] kf_reg;

    // Loop state
    logic signed [31:0] xa_reg;
    logic signed [31:0] xb_reg;
    logic signed [18:0] angle_reg;
    logic signed [31:0] integ_reg;
    logic signed [31:0] acc_reg;

    // Working values of one word
    logic signed [31:0] ia_reg;
    logic signed [31:0] ib_reg;
    logic signed [31:0] ua_reg;
    logic signed [31:0] ub_reg;
    logic signed [31:0] ya_reg;
    logic signed [31:0] yb_reg;
    logic signed [31:0] ea_reg;
    logic signed [31:0] eb_reg;
    logic signed [63:0] r2_reg;
    logic signed [63:0] s_reg;
    logic signed [63:0] t_reg;
    logic signed [31:0] da_reg;
    logic signed [31:0] db_reg;
    logic signed [18:0] theta_reg;
    logic signed [18:0] e_reg;
    logic signed [31:0] spd_reg;
    logic signed [31:0] rpm_reg;
    logic               wrap_need_reg;
    logic               wrap_neg_reg;
    logic [29:0]        wrap_u_reg;

    // Result word
    logic signed [18:0] out_angle_reg;
    logic signed [18:0] out_theta_reg;
    logic signed [31:0] out_spd_reg;
    logic signed [31:0] out_rpm_reg;

    logic signed [63:0] mul_a;
    logic signed [63:0] mul_b;
    sh_t                mul_sh;
    logic               mul_done;
    logic signed [63:0] p;
    logic signed [65:0] p66;
    logic               cordic_done;
    logic signed [18:0] cordic_angle;
    logic [16:0]        k_eff;
    logic [16:0]        k_rest;
    logic signed [19:0] err_raw;
    logic signed [18:0] err_wrapped;
    logic signed [65:0] ang_sum;
    logic [29:0]        wrap_div;
    logic [29:0]        wrap_red;
    logic signed [30:0] wrap_fin;

    always_comb
    begin
        k_eff  = (kf_reg > 17'(K_ONE)) ? 17'(K_ONE) : kf_reg;
        k_rest = 17'(K_ONE) - k_eff;
        case (cmd.op)
            OP_RS_IA:   begin mul_a = 64'(rs_reg);  mul_b = 64'(ia_reg);  mul_sh = SH_16; end
            OP_RS_IB:   begin mul_a = 64'(rs_reg);  mul_b = 64'(ib_reg);  mul_sh = SH_16; end
            OP_LS_IA:   begin mul_a = 64'(ls_reg);  mul_b = 64'(ia_reg);  mul_sh = SH_32; end
            OP_LS_IB:   begin mul_a = 64'(ls_reg);  mul_b = 64'(ib_reg);  mul_sh = SH_32; end
            OP_EA_SQ:   begin mul_a = 64'(ea_reg);  mul_b = 64'(ea_reg);  mul_sh = SH_0;  end
            OP_EB_SQ:   begin mul_a = 64'(eb_reg);  mul_b = 64'(eb_reg);  mul_sh = SH_0;  end
            OP_PSI_SQ:  begin mul_a = 64'(psi_reg); mul_b = 64'(psi_reg); mul_sh = SH_32; end
            OP_EA_GAM:  begin mul_a = 64'(ea_reg);  mul_b = 64'(gam_reg); mul_sh = SH_0;  end
            OP_TA_S:    begin mul_a = t_reg;        mul_b = s_reg;        mul_sh = SH_33; end
            OP_EB_GAM:  begin mul_a = 64'(eb_reg);  mul_b = 64'(gam_reg); mul_sh = SH_0;  end
            OP_TB_S:    begin mul_a = t_reg;        mul_b = s_reg;        mul_sh = SH_33; end
            OP_TS_DA:   begin mul_a = 64'(ts_reg);  mul_b = 64'(da_reg);  mul_sh = SH_32; end
            OP_TS_DB:   begin mul_a = 64'(ts_reg);  mul_b = 64'(db_reg);  mul_sh = SH_32; end
            OP_KI_E:    begin mul_a = 64'(ki_reg);  mul_b = 64'(e_reg);   mul_sh = SH_16; end
            OP_KP_E:    begin mul_a = 64'(kp_reg);  mul_b = 64'(e_reg);   mul_sh = SH_16; end
            OP_TS_SPD:  begin mul_a = 64'(ts_reg);  mul_b = 64'(spd_reg); mul_sh = SH_32; end
            OP_SPD_RPM: begin mul_a = 64'(spd_reg); mul_b = RPM_FACTOR;   mul_sh = SH_32; end
            OP_ACC_K:   begin mul_a = 64'(acc_reg); mul_b = 64'(k_rest);  mul_sh = SH_0;  end
            OP_RPM_K:   begin mul_a = 64'(rpm_reg); mul_b = 64'(k_eff);   mul_sh = SH_0;  end
            default:    begin mul_a = 64'sd0;       mul_b = 64'sd0;       mul_sh = SH_0;  end
        endcase
    end

    pfo_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .sh    (mul_sh),
        .done  (mul_done),
        .p     (p)
    );

    pfo_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.cordic_start),
        .x_in  (ea_reg),
        .y_in  (eb_reg),
        .done  (cordic_done),
        .angle (cordic_angle)
    );

    assign status.mul_done    = mul_done;
    assign status.cordic_done = cordic_done;

    always_comb
    begin
        p66     = 66'(p);
        ang_sum = 66'(angle_reg) + p66;
        err_raw = 20'(cordic_angle) - 20'(angle_reg);
        if (err_raw > 20'(PI_Q))
            err_wrapped = 19'(err_raw - 20'(TWO_PI_Q));
        else if (err_raw < -20'(PI_Q))
            err_wrapped = 19'(err_raw + 20'(TWO_PI_Q));
        else
            err_wrapped = err_raw[18:0];
        // Restoring reduction modulo two pi, one multiple of 2^shift per step.
        wrap_div = 30'(TWO_PI_Q) << cmd.wrap_shift;
        wrap_red = (wrap_u_reg >= wrap_div) ? wrap_u_reg - wrap_div : wrap_u_reg;
        if (wrap_neg_reg)
            wrap_fin = 31'(PI_Q - 1) - signed'({1'b0, wrap_red});
        else
            wrap_fin = signed'({1'b0, wrap_red}) + 31'(1 - PI_Q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_reg  <= '0;
            ls_reg  <= '0;
            psi_reg <= '0;
            gam_reg <= '0;
            ts_reg  <= '0;
            kp_reg  <= '0;
            ki_reg  <= '0;
            kf_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_RS:  rs_reg  <= cfg_data[22:0];
                REG_LS:  ls_reg  <= cfg_data;
                REG_PSI: psi_reg <= cfg_data;
                REG_GAM: gam_reg <= cfg_data;
                REG_TS:  ts_reg  <= cfg_data;
                REG_KP:  kp_reg  <= cfg_data;
                REG_KI:  ki_reg  <= cfg_data;
                REG_KF:  kf_reg  <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xa_reg    <= '0;
            xb_reg    <= '0;
            angle_reg <= '0;
            integ_reg <= '0;
            acc_reg   <= '0;
        end
        else if (mul_done)
        begin
            case (cmd.op)
                OP_TS_DA:  xa_reg    <= sat32(66'(xa_reg) + p66);
                OP_TS_DB:  xb_reg    <= sat32(66'(xb_reg) + p66);
                OP_KI_E:   integ_reg <= clamp_speed(66'(integ_reg) + p66);
                OP_TS_SPD:
                begin
                    if ((ang_sum <= 66'(PI_Q)) && (ang_sum >= -66'(PI_Q)))
                        angle_reg <= ang_sum[18:0];
                end
                OP_RPM_K:  acc_reg   <= sat32((66'(t_reg) + p66) >>> 16);
                default: ;
            endcase
        end
        else if (cmd.wrap_step && wrap_need_reg && (cmd.wrap_shift == 4'd0))
        begin
            angle_reg <= wrap_fin[18:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            ia_reg <= current_alpha;
            ib_reg <= current_beta;
            ua_reg <= voltage_alpha;
            ub_reg <= voltage_beta;
        end
        if (cmd.load_out)
        begin
            out_angle_reg <= angle_reg;
            out_theta_reg <= theta_reg;
            out_spd_reg   <= spd_reg;
            out_rpm_reg   <= acc_reg;
        end
        if (cordic_done)
        begin
            theta_reg <= cordic_angle;
            e_reg     <= err_wrapped;
        end
        if (cmd.wrap_step)
            wrap_u_reg <= wrap_red;
        if (mul_done)
        begin
            case (cmd.op)
                OP_RS_IA:   ya_reg  <= sat32(66'(ua_reg) - p66);
                OP_RS_IB:   yb_reg  <= sat32(66'(ub_reg) - p66);
                OP_LS_IA:   ea_reg  <= sat32(66'(xa_reg) - p66);
                OP_LS_IB:   eb_reg  <= sat32(66'(xb_reg) - p66);
                OP_EA_SQ:   r2_reg  <= p;
                OP_EB_SQ:   r2_reg  <= sat64(66'(r2_reg) + p66);
                OP_PSI_SQ:  s_reg   <= sat64(p66 - 66'(r2_reg));
                OP_EA_GAM:  t_reg   <= p;
                OP_TA_S:    da_reg  <= sat32(66'(ya_reg) + p66);
                OP_EB_GAM:  t_reg   <= p;
                OP_TB_S:    db_reg  <= sat32(66'(yb_reg) + p66);
                OP_KP_E:    spd_reg <= clamp_speed(p66 + 66'(integ_reg));
                OP_TS_SPD:
                begin
                    if (ang_sum > 66'(PI_Q))
                    begin
                        wrap_need_reg <= 1'b1;
                        wrap_neg_reg  <= 1'b0;
                        wrap_u_reg    <= 30'(ang_sum - 66'(PI_Q) - 66'sd1);
                    end
                    else if (ang_sum < -66'(PI_Q))
                    begin
                        wrap_need_reg <= 1'b1;
                        wrap_neg_reg  <= 1'b1;
                        wrap_u_reg    <= 30'(-66'(PI_Q) - 66'sd1 - ang_sum);
                    end
                    else
                    begin
                        wrap_need_reg <= 1'b0;
                    end
                end
                OP_SPD_RPM: rpm_reg <= sat32(p66);
                OP_ACC_K:   t_reg   <= p;
                default: ;
            endcase
        end
    end

    assign rotor_angle        = out_angle_reg;
    assign flux_angle         = out_theta_reg;
    assign elec_speed         = out_spd_reg;
    assign speed_rpm_filtered = out_rpm_reg;

endmodule

/* hdl/pfo_ctrl.sv */
// Sequencer that steps the datapath through one observer and PLL update per word.
module pfo_ctrl
    import pfo_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_IDLE        = 7'b0000001,
        S_MUL_GO      = 7'b0000010,
        S_MUL_WAIT    = 7'b0000100,
        S_CORDIC_GO   = 7'b0001000,
        S_CORDIC_WAIT = 7'b0010000,
        S_WRAP        = 7'b0100000,
        S_FINISH      = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    op_t        op_reg, op_next;
    logic [3:0] wrap_cnt_reg, wrap_cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        wrap_cnt_next = wrap_cnt_reg;
        cmd           = '0;
        cmd.op        = op_reg;
        cmd.wrap_shift = wrap_cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    op_next     = OP_RS_IA;
                    state_next  = S_MUL_GO;
                end
            end
            S_MUL_GO:
            begin
                cmd.mul_start = 1'b1;
                state_next    = S_MUL_WAIT;
            end
            S_MUL_WAIT:
            begin
                if (status.mul_done)
                begin
                    case (op_reg)
                        OP_TS_DB:  state_next = S_CORDIC_GO;
                        OP_TS_SPD:
                        begin
                            wrap_cnt_next = 4'(WRAP_STEPS - 1);
                            state_next    = S_WRAP;
                        end
                        OP_RPM_K:  state_next = S_FINISH;
                        default:
                        begin
                            op_next    = op_t'(op_reg + 5'd1);
                            state_next = S_MUL_GO;
                        end
                    endcase
                end
            end
            S_CORDIC_GO:
            begin
                cmd.cordic_start = 1'b1;
                state_next       = S_CORDIC_WAIT;
            end
            S_CORDIC_WAIT:
            begin
                if (status.cordic_done)
                begin
                    op_next    = OP_KI_E;
                    state_next = S_MUL_GO;
                end
            end
            S_WRAP:
            begin
                cmd.wrap_step = 1'b1;
                if (wrap_cnt_reg == 4'd0)
                begin
                    op_next    = OP_SPD_RPM;
                    state_next = S_MUL_GO;
                end
                else
                begin
                    wrap_cnt_next = wrap_cnt_reg - 4'd1;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (cmd.load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_RS_IA;
            wrap_cnt_reg  <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            wrap_cnt_reg  <= wrap_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* hdl/pmsm_flux_observer_pll_top.sv */
// Top level of the PMSM nonlinear flux observer with PI phase-locked loop.
// One input word (alpha/beta currents and voltages, Q16.16) gives one result word:
// PLL rotor angle, raw flux angle, electrical speed and filtered mechanical rpm.
// The block works on one word at a time. Each word runs through the 19 multiplies that
// share one 32x32 multiplier (four partial products plus rounding and saturation), the
// 17-iteration CORDIC, 11 angle-wrap steps and the accept and finish states. A new word
// is accepted as soon as the previous one has been moved into the output register, even
// while that result is still stalled. Configuration registers must be written only
// while the block is idle; the block itself does not enforce this.
module pmsm_flux_observer_pll_top
    import pfo_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] current_alpha,
    input  logic signed [31:0] current_beta,
    input  logic signed [31:0] voltage_alpha,
    input  logic signed [31:0] voltage_beta,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [18:0] rotor_angle,
    output logic signed [18:0] flux_angle,
    output logic signed [31:0] elec_speed,
    output logic signed [31:0] speed_rpm_filtered
);

    cmd_t    cmd;
    status_t status;

    pfo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    pfo_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .current_alpha      (current_alpha),
        .current_beta       (current_beta),
        .voltage_alpha      (voltage_alpha),
        .voltage_beta       (voltage_beta),
        .cmd                (cmd),
        .status             (status),
        .rotor_angle        (rotor_angle),
        .flux_angle         (flux_angle),
        .elec_speed         (elec_speed),
        .speed_rpm_filtered (speed_rpm_filtered)
    );

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the PMSM flux observer and PLL with a bit-exact observer model.
module testbench;
    import pfo_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  HALF_PERIOD  = 6;
    localparam int  DRAIN_CYCLES = 400;
    localparam int  HOLD_CYCLES  = 3000;
    localparam int  HOLD_AT      = 700;
    localparam int  QUIET_FROM   = 200;
    localparam int  QUIET_TO     = 420;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        logic signed [18:0] rotor;
        logic signed [18:0] flux;
        logic signed [31:0] speed;
        logic signed [31:0] rpm;
    } obs_result_t;

    typedef struct {
        logic signed [31:0] ia, ib, ua, ub;
        bit                 typed;
        obs_result_t        known;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [31:0] current_alpha = '0;
    logic signed [31:0] current_beta = '0;
    logic signed [31:0] voltage_alpha = '0;
    logic signed [31:0] voltage_beta = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [18:0] rotor_angle;
    logic signed [18:0] flux_angle;
    logic signed [31:0] elec_speed;
    logic signed [31:0] speed_rpm_filtered;

    pmsm_flux_observer_pll_top DUT (.*);

    always #(HALF_PERIOD) clk = ~clk;

    // Mirror of the configuration and observer state.
    longint rs_m, ls_m, psi_m, gam_m, ts_m, kp_m, ki_m, kf_m;
    longint xhat_a, xhat_b, angle_m, integ_m, filt_m;

    obs_result_t pending_results[$];
    int  words_in = 0;
    int  words_out = 0;
    int  mismatches = 0;
    longint cycles = 0;

    function automatic longint sat_to64(logic signed [127:0] v);
        logic signed [127:0] hi, lo;
        hi = 64'sh7FFF_FFFF_FFFF_FFFF;
        lo = -128'sh8000_0000_0000_0000;
        if (v > hi) return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (v < lo) return 64'sh8000_0000_0000_0000;
        return longint'(v[63:0]);
    endfunction

    function automatic longint sat_to32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint lim(longint v, longint l);
        return v > l ? l : (v < -l ? -l : v);
    endfunction

    // Exact product, floor-shifted, saturated to 64 bits.
    function automatic longint prod_floor(longint a, longint b, int sh);
        logic signed [127:0] pa, pb, p;
        pa = a;
        pb = b;
        p = (pa * pb) >>> sh;
        return sat_to64(p);
    endfunction

    function automatic longint add_sat(longint a, longint b);
        logic signed [127:0] pa, pb;
        pa = a;
        pb = b;
        return sat_to64(pa + pb);
    endfunction

    function automatic longint flux_atan(longint y, longint x);
        longint z, dx, dy;
        longint steps [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
                               128, 64, 32, 16, 8, 4, 2, 1};
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0)
        begin
            z = (y >= 0) ? PI_Q : -PI_Q;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x += dx; y -= dy; z += steps[i];
            end
            else
            begin
                x -= dx; y += dy; z -= steps[i];
            end
        end
        return lim(z, PI_Q);
    endfunction

    function automatic longint wrap_pi(longint v);
        longint m;
        if (v > PI_Q)
        begin
            m = (PI_Q - v) % TWO_PI_Q;
            if (m < 0) m += TWO_PI_Q;
            return PI_Q - m;
        end
        if (v < -PI_Q)
        begin
            m = (v + PI_Q) % TWO_PI_Q;
            if (m < 0) m += TWO_PI_Q;
            return m - PI_Q;
        end
        return v;
    endfunction

    function automatic obs_result_t observe_step(longint ia, longint ib, longint ua, longint ub);
        obs_result_t r;
        longint ya, yb, ea, eb, r2, s, da, db, theta, err, spd, rpm, k;
        k = kf_m > K_ONE ? K_ONE : kf_m;
        ya = sat_to32(ua - prod_floor(rs_m, ia, 16));
        yb = sat_to32(ub - prod_floor(rs_m, ib, 16));
        ea = sat_to32(xhat_a - prod_floor(ls_m, ia, 32));
        eb = sat_to32(xhat_b - prod_floor(ls_m, ib, 32));
        r2 = add_sat(ea * ea, eb * eb);
        s = add_sat(prod_floor(psi_m, psi_m, 32), -r2);
        da = sat_to32(add_sat(ya, prod_floor(ea * gam_m, s, 33)));
        db = sat_to32(add_sat(yb, prod_floor(eb * gam_m, s, 33)));
        xhat_a = sat_to32(xhat_a + prod_floor(ts_m, da, 32));
        xhat_b = sat_to32(xhat_b + prod_floor(ts_m, db, 32));
        theta = flux_atan(eb, ea);
        err = theta - angle_m;
        if (err > PI_Q) err -= TWO_PI_Q;
        else if (err < -PI_Q) err += TWO_PI_Q;
        integ_m = lim(integ_m + prod_floor(ki_m, err, 16), SPEED_LIMIT);
        spd = lim(prod_floor(kp_m, err, 16) + integ_m, SPEED_LIMIT);
        angle_m = wrap_pi(angle_m + prod_floor(ts_m, spd, 32));
        rpm = sat_to32(prod_floor(spd, RPM_FACTOR, 32));
        filt_m = sat_to32((filt_m * (K_ONE - k) + rpm * k) >>> 16);
        r.rotor = angle_m[18:0];
        r.flux = theta[18:0];
        r.speed = spd[31:0];
        r.rpm = filt_m[31:0];
        return r;
    endfunction

    function automatic bit quiet_window();
        return words_in >= QUIET_FROM && words_in < QUIET_TO;
    endfunction

    // The write enable stays high across a burst; the caller drops it afterwards.
    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_RS:  rs_m = val & 32'h7F_FFFF;
            REG_LS:  ls_m = val;
            REG_PSI: psi_m = val;
            REG_GAM: gam_m = val;
            REG_TS:  ts_m = val;
            REG_KP:  kp_m = val;
            REG_KI:  ki_m = val;
            REG_KF:  kf_m = val & 32'h1_FFFF;
            default: ;
        endcase
    endtask

    // Registers change only once the block has drained.
    task automatic load_settings(logic [31:0] rs, logic [31:0] ls, logic [31:0] psi,
                                 logic [31:0] gam, logic [31:0] ts, logic [31:0] kp,
                                 logic [31:0] ki, logic [31:0] kf);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        write_reg(REG_RS, rs);
        write_reg(REG_LS, ls);
        write_reg(REG_PSI, psi);
        write_reg(REG_GAM, gam);
        write_reg(REG_TS, ts);
        write_reg(REG_KP, kp);
        write_reg(REG_KI, ki);
        write_reg(REG_KF, kf);
        cfg_we <= 1'b0;
    endtask

    task automatic send_word(logic signed [31:0] ia, logic signed [31:0] ib,
                             logic signed [31:0] ua, logic signed [31:0] ub,
                             bit typed, obs_result_t known);
        obs_result_t predicted;
        int gap;
        in_valid <= 1'b1;
        current_alpha <= ia;
        current_beta <= ib;
        voltage_alpha <= ua;
        voltage_beta <= ub;
        do @(posedge clk); while (in_stall);
        predicted = observe_step(ia, ib, ua, ub);
        pending_results.push_back(typed ? known : predicted);
        words_in++;
        if (!quiet_window() && $urandom_range(0, 99) < 8)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic signed [31:0] rand_word();
        logic signed [31:0] v;
        case ($urandom_range(0, 5))
            0: v = 32'sh7FFF_FFFF;
            1: v = 32'sh8000_0000;
            2: v = $signed($urandom_range(0, 1 << 20)) - (1 <<< 19);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Receiver: checks each word and stalls at random, with one long hold-off.
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    always @(posedge clk)
    begin
        obs_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            words_out <= words_out + 1;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result word at cycle %0d", cycles);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rotor_angle !== want.rotor || flux_angle !== want.flux ||
                    elec_speed !== want.speed || speed_rpm_filtered !== want.rpm)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch word %0d: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                 words_out, want.rotor, want.flux, want.speed, want.rpm,
                                 rotor_angle, flux_angle, elec_speed, speed_rpm_filtered);
                end
            end
        end
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (!hold_done && words_in >= HOLD_AT)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (quiet_window())
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < 8);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    stim_row_t script[$];

    task automatic add_row(logic signed [31:0] ia, logic signed [31:0] ib,
                           logic signed [31:0] ua, logic signed [31:0] ub, bit typed);
        stim_row_t r;
        r.ia = ia; r.ib = ib; r.ua = ua; r.ub = ub;
        r.typed = typed;
        r.known = '{default: '0};
        script.push_back(r);
    endtask

    initial
    begin
        localparam int ZERO_ROWS = 6;
        obs_result_t none;
        real ph, w, amp, iamp;
        int  seq_len;
        logic signed [31:0] ia, ib, ua, ub;
        none = '{default: '0};
        xhat_a = 0; xhat_b = 0; angle_m = 0; integ_m = 0; filt_m = 0;
        rs_m = 0; ls_m = 0; psi_m = 0; gam_m = 0; ts_m = 0; kp_m = 0; ki_m = 0; kf_m = 0;

        // With every register at zero after reset, all outputs stay zero.
        add_row(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
        add_row(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
        add_row(0, 0, 0, 0, 1'b1);
        add_row(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
        add_row(32'sh0001_0000, -32'sh0001_0000, 32'sh0010_0000, 0, 1'b1);
        add_row(-1, 1, -1, 1, 1'b1);
        // Nominal settings: zero flux vector first, then extremes and quadrants.
        add_row(0, 0, 0, 0, 1'b0);
        add_row(0, 0, 32'sh0020_0000, 0, 1'b0);
        add_row(0, 0, 0, 32'sh0020_0000, 1'b0);
        add_row(0, 0, -32'sh0040_0000, 0, 1'b0);
        add_row(0, 0, 0, -32'sh0040_0000, 1'b0);
        add_row(0, 0, -32'sh0040_0000, 32'sh0001_0000, 1'b0);
        add_row(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 1'b0);
        add_row(32'sh8000_0000, 32'sh8000_0000, 0, 0, 1'b0);
        add_row(0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
        add_row(0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
        add_row(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
        add_row(32'sh0005_0000, -32'sh0003_0000, 32'sh0030_0000, -32'sh0010_0000, 1'b0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (i == ZERO_ROWS)
                load_settings(32768, 4294967, 42949673, 1000, 429497,
                              100 * 65536, 5 * 65536, 2000);
            send_word(script[i].ia, script[i].ib, script[i].ua, script[i].ub,
                      script[i].typed, script[i].known);
        end

        // Rotating voltage and current vectors drive the observer and the PLL.
        ph = 0.0;
        while (words_in < 480)
        begin
            w = ($urandom_range(1, 400) - 200) / 1000.0;
            amp = $urandom_range(1, 400);
            iamp = $urandom_range(0, 30);
            seq_len = $urandom_range(20, 80);
            repeat (seq_len)
            begin
                ph += w;
                ia = $rtoi(iamp * $cos(ph - 0.3) * 65536.0) + $signed($urandom_range(0, 255));
                ib = $rtoi(iamp * $sin(ph - 0.3) * 65536.0);
                ua = $rtoi(amp * $cos(ph) * 65536.0);
                ub = $rtoi(amp * $sin(ph) * 65536.0);
                if ($urandom_range(0, 99) < 15) ua = rand_word();
                send_word(ia, ib, ua, ub, 1'b0, none);
            end
        end

        // Every register at its top code, full-range inputs.
        load_settings(32'h7F_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1_FFFF);
        repeat (200) send_word(rand_word(), rand_word(), rand_word(), rand_word(), 1'b0, none);

        // Random settings, mostly rotating words with random content.
        repeat (6)
        begin
            load_settings($urandom & 32'h7F_FFFF, $urandom >> $urandom_range(0, 20),
                          $urandom >> $urandom_range(0, 8), $urandom >> $urandom_range(0, 28),
                          $urandom >> $urandom_range(0, 16), $urandom >> $urandom_range(0, 12),
                          $urandom >> $urandom_range(0, 16), $urandom_range(0, 70000));
            ph = 0.0;
            w = ($urandom_range(1, 400) - 200) / 1000.0;
            amp = $urandom_range(1, 2000);
            repeat (100)
            begin
                ph += w;
                if ($urandom_range(0, 99) < 75)
                    send_word($signed($urandom_range(0, 1 << 21)) - (1 <<< 20),
                              $signed($urandom_range(0, 1 << 21)) - (1 <<< 20),
                              $rtoi(amp * $cos(ph) * 65536.0),
                              $rtoi(amp * $sin(ph) * 65536.0), 1'b0, none);
                else
                    send_word(rand_word(), rand_word(), rand_word(), rand_word(), 1'b0, none);
            end
        end

        // Back to zero settings with the observer state left as it is.
        load_settings(0, 0, 0, 0, 0, 0, 0, 0);
        repeat (30) send_word(rand_word(), rand_word(), rand_word(), rand_word(), 1'b0, none);

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
